// ----- sv/packed_4bpp_frame_drawing_defines.svh -----
// Assertion macros used by the drawing engine top module.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef PACKED_4BPP_FRAME_DRAWING_DEFINES_SVH
`define PACKED_4BPP_FRAME_DRAWING_DEFINES_SVH

// Same-cycle implication
`define P4FD_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define P4FD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/p4fd_pkg.sv -----
package p4fd_pkg;

    // Coordinate width inside the engine: holds start + thickness and end + overhang
    localparam int CW = 11;

    localparam int CMD_W   = 3;
    localparam int COLOR_W = 4;

    // Stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HLINE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VLINE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BOX   = 3'd5;

    // Configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_OVERHANG = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_COLOR   = 1'b1;
    localparam logic [CFG_DATA_W-1:0]  OVERHANG_RESET    = 4'd4;
    localparam logic [CFG_DATA_W-1:0]  CLEAR_COLOR_RESET = 4'd0;

    // Microcode
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,   // set up rectangle walker
        ACT_WALK   = 2'd1,   // one write per cycle (a pixel, or a byte for clear) until the rectangle is done
        ACT_READ   = 2'd2,   // issue a single pixel read
        ACT_FINISH = 2'd3    // drain pipeline and post the result
    } act_t;

    typedef enum logic [2:0] {
        SEG_FULL   = 3'd0,
        SEG_POINT  = 3'd1,
        SEG_HTOP   = 3'd2,
        SEG_HBOT   = 3'd3,
        SEG_VLEFT  = 3'd4,
        SEG_VRIGHT = 3'd5
    } seg_t;

    typedef enum logic [1:0] {
        JMP_NEXT   = 2'd0,
        JMP_ALWAYS = 2'd1,
        JMP_ON_ERR = 2'd2
    } jmp_t;

    localparam int STEP_W     = 5;
    localparam int PROG_DEPTH = 17;

    localparam logic [STEP_W-1:0] STEP_CLEAR  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_WALK   = 5'd1;
    localparam logic [STEP_W-1:0] STEP_FINISH = 5'd2;
    localparam logic [STEP_W-1:0] STEP_WRITE  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_READ   = 5'd4;
    localparam logic [STEP_W-1:0] STEP_HLINE  = 5'd5;
    localparam logic [STEP_W-1:0] STEP_VLINE  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_BOX    = 5'd9;

    typedef struct packed {
        act_t              act;
        seg_t              seg;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ctl_word_t;

    // Control store
    localparam ctl_word_t PROGRAM [PROG_DEPTH] = '{
        '{ACT_LOAD,   SEG_FULL,   JMP_NEXT,   STEP_FINISH},   // clear
        '{ACT_WALK,   SEG_FULL,   JMP_NEXT,   STEP_FINISH},   // shared walk
        '{ACT_FINISH, SEG_FULL,   JMP_NEXT,   STEP_FINISH},   // result
        '{ACT_LOAD,   SEG_POINT,  JMP_ALWAYS, STEP_WALK},     // write pixel
        '{ACT_READ,   SEG_POINT,  JMP_ALWAYS, STEP_FINISH},   // read pixel
        '{ACT_LOAD,   SEG_HTOP,   JMP_ON_ERR, STEP_FINISH},   // hline
        '{ACT_WALK,   SEG_HTOP,   JMP_ALWAYS, STEP_FINISH},
        '{ACT_LOAD,   SEG_VLEFT,  JMP_ON_ERR, STEP_FINISH},   // vline
        '{ACT_WALK,   SEG_VLEFT,  JMP_ALWAYS, STEP_FINISH},
        '{ACT_LOAD,   SEG_HTOP,   JMP_ON_ERR, STEP_FINISH},   // box: top
        '{ACT_WALK,   SEG_HTOP,   JMP_NEXT,   STEP_FINISH},
        '{ACT_LOAD,   SEG_HBOT,   JMP_NEXT,   STEP_FINISH},   // bottom
        '{ACT_WALK,   SEG_HBOT,   JMP_NEXT,   STEP_FINISH},
        '{ACT_LOAD,   SEG_VLEFT,  JMP_NEXT,   STEP_FINISH},   // left
        '{ACT_WALK,   SEG_VLEFT,  JMP_NEXT,   STEP_FINISH},
        '{ACT_LOAD,   SEG_VRIGHT, JMP_NEXT,   STEP_FINISH},   // right
        '{ACT_WALK,   SEG_VRIGHT, JMP_ALWAYS, STEP_FINISH}
    };

    // Dispatch: first step of each command
    function automatic logic [STEP_W-1:0] entry_step(input logic [CMD_W-1:0] cmd);
        case (cmd)
            CMD_CLEAR: return STEP_CLEAR;
            CMD_WRITE: return STEP_WRITE;
            CMD_READ:  return STEP_READ;
            CMD_HLINE: return STEP_HLINE;
            CMD_VLINE: return STEP_VLINE;
            CMD_BOX:   return STEP_BOX;
            default:   return STEP_FINISH;
        endcase
    endfunction

    // Pixel request control between sequencer and frame memory
    typedef struct packed {
        logic valid;
        logic write;   // 0: read
        logic both;    // write both nibbles of the byte (clear)
    } px_ctl_t;

endpackage

// ----- sv/packed_4bpp_frame_drawing.sv -----
// Channel  Dir  Fields (low bit first)
// s_*      in   cmd[2:0] x_start[11:3] y_start[19:12] x_end[28:20] y_end[36:29]
//               pen_color[40:37] thickness[46:41]
// m_*      out  read_color[3:0] range_error[4]
// cfg_*    in   0 line_overhang, 1 clear_color (write only)
//
// One command at a time; a microcoded walker issues one pixel write per cycle to
// the single frame store port, with dispatch, setup and drain steps around it.
// Clear writes one byte (two pixels) per cycle. Lines are clipped to the frame,
// and a box is drawn as four lines.
// Reset clears control only; frame contents are undefined until drawn.
// A new command is taken while the previous result waits on m_tready.
`include "packed_4bpp_frame_drawing_defines.svh"

module packed_4bpp_frame_drawing
    import p4fd_pkg::*;
#(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // cmd, x_start, y_start, x_end, y_end,
                                              // pen_color, thickness
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // read_color, range_error
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ROW_BYTES = (FRAME_WIDTH + 1) / 2;
    localparam int XW        = $clog2(FRAME_WIDTH);
    localparam int YW        = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int XA_W      = CW + 1;
    localparam logic [CW-1:0] X_MAX = CW'(FRAME_WIDTH - 1);
    localparam logic [CW-1:0] Y_MAX = CW'(FRAME_HEIGHT - 1);

    // Input field unpack
    logic [CMD_W-1:0]   cmd_in;
    logic [8:0]         xs_in;
    logic [7:0]         ys_in;
    logic [8:0]         xe_in;
    logic [7:0]         ye_in;
    logic [COLOR_W-1:0] pen_in;
    logic [5:0]         thick_in;

    assign cmd_in   = s_tdata[2:0];
    assign xs_in    = s_tdata[11:3];
    assign ys_in    = s_tdata[19:12];
    assign xe_in    = s_tdata[28:20];
    assign ye_in    = s_tdata[36:29];
    assign pen_in   = s_tdata[40:37];
    assign thick_in = s_tdata[46:41];

    // Control state
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [CFG_DATA_W-1:0]  overhang_reg;
    logic [CFG_DATA_W-1:0]  clear_color_reg;
    px_ctl_t           px_ctl_reg, px_ctl_next;

    // Command payload
    logic [CMD_W-1:0]   cmd_reg;
    logic [8:0]         xs_reg;
    logic [7:0]         ys_reg;
    logic [8:0]         xe_reg;
    logic [7:0]         ye_reg;
    logic [COLOR_W-1:0] pen_reg;
    logic [5:0]         thick_reg;
    logic               err_reg, err_next;

    // Rectangle walker
    logic [CW-1:0] cx_reg, cy_reg, x0_reg, x1_reg, y1_reg;
    logic          empty_reg, both_reg;
    logic [XW-1:0]      px_x_reg;
    logic [YW-1:0]      px_y_reg;
    logic [COLOR_W-1:0] px_color_reg;

    ctl_word_t ctl;
    logic      accept;
    logic      load_rect, emit_walk, emit_read, advance, seq_finish;
    logic      drained, out_free, rd_in;
    logic      mem_busy;
    logic [COLOR_W-1:0] rd_color;
    logic [COLOR_W-1:0] read_color;

    logic [CW-1:0] r_x0, r_x1, r_y0, r_y1, x1c, y1c;
    logic          r_line, r_empty;
    logic [XA_W-1:0] x_adv;
    logic          x_last, y_last, rect_done;

    assign ctl      = PROGRAM[step_reg];
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign drained  = !px_ctl_reg.valid && !mem_busy;
    assign out_free = !out_valid_reg || m_tready;
    assign rd_in    = (CW'(xs_reg) <= X_MAX) && (CW'(ys_reg) <= Y_MAX);

    // Range check at dispatch
    always_comb
    begin
        case (cmd_in)
            CMD_HLINE: err_next = xe_in < xs_in;
            CMD_VLINE: err_next = ye_in < ys_in;
            CMD_BOX:   err_next = (xe_in < xs_in) || (ye_in < ys_in);
            default:   err_next = 1'b0;
        endcase
    end

    // Rectangle for the current segment
    always_comb
    begin
        r_x0   = CW'(1);
        r_x1   = '0;
        r_y0   = '0;
        r_y1   = '0;
        r_line = 1'b0;
        case (ctl.seg)
            SEG_FULL:
            begin
                r_x0 = '0;
                r_x1 = X_MAX;
                r_y1 = Y_MAX;
            end
            SEG_POINT:
            begin
                r_x0 = CW'(xs_reg);
                r_x1 = CW'(xs_reg);
                r_y0 = CW'(ys_reg);
                r_y1 = CW'(ys_reg);
            end
            SEG_HTOP:
            begin
                r_x0   = CW'(xs_reg);
                r_x1   = CW'(xe_reg) + CW'(overhang_reg);
                r_y0   = CW'(ys_reg);
                r_y1   = CW'(ys_reg) + CW'(thick_reg) - CW'(1);
                r_line = 1'b1;
            end
            SEG_HBOT:
            begin
                r_x0   = CW'(xs_reg);
                r_x1   = CW'(xe_reg) + CW'(overhang_reg);
                r_y0   = CW'(ye_reg);
                r_y1   = CW'(ye_reg) + CW'(thick_reg) - CW'(1);
                r_line = 1'b1;
            end
            SEG_VLEFT:
            begin
                r_x0   = CW'(xs_reg);
                r_x1   = CW'(xs_reg) + CW'(thick_reg) - CW'(1);
                r_y0   = CW'(ys_reg);
                r_y1   = CW'(ye_reg) + CW'(overhang_reg);
                r_line = 1'b1;
            end
            SEG_VRIGHT:
            begin
                r_x0   = CW'(xe_reg);
                r_x1   = CW'(xe_reg) + CW'(thick_reg) - CW'(1);
                r_y0   = CW'(ys_reg);
                r_y1   = CW'(ye_reg) + CW'(overhang_reg);
                r_line = 1'b1;
            end
            default:
            begin
                r_line = 1'b0;
            end
        endcase
        // clip to the frame
        x1c     = (r_x1 > X_MAX) ? X_MAX : r_x1;
        y1c     = (r_y1 > Y_MAX) ? Y_MAX : r_y1;
        r_empty = (r_line && (thick_reg == '0)) || (r_x0 > x1c) || (r_y0 > y1c);
    end

    // Walker position; clear steps two pixels (one byte) at a time
    assign x_adv     = {1'b0, cx_reg} + (both_reg ? XA_W'(2) : XA_W'(1));
    assign x_last    = x_adv > {1'b0, x1_reg};
    assign y_last    = cy_reg == y1_reg;
    assign rect_done = empty_reg || (x_last && y_last);

    // Sequencer
    always_comb
    begin
        step_next  = step_reg;
        busy_next  = busy_reg;
        load_rect  = 1'b0;
        emit_walk  = 1'b0;
        emit_read  = 1'b0;
        advance    = 1'b0;
        seq_finish = 1'b0;
        if (accept)
        begin
            step_next = entry_step(cmd_in);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (ctl.act)
                ACT_LOAD:
                begin
                    load_rect = 1'b1;
                    advance   = 1'b1;
                end
                ACT_WALK:
                begin
                    emit_walk = !empty_reg;
                    advance   = rect_done;
                end
                ACT_READ:
                begin
                    emit_read = rd_in;
                    advance   = 1'b1;
                end
                ACT_FINISH:
                begin
                    if (drained && out_free)
                    begin
                        seq_finish = 1'b1;
                        busy_next  = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            if (advance)
            begin
                case (ctl.jmp)
                    JMP_NEXT:   step_next = step_reg + STEP_W'(1);
                    JMP_ALWAYS: step_next = ctl.target;
                    JMP_ON_ERR: step_next = err_reg ? ctl.target : step_reg + STEP_W'(1);
                    default:    step_next = ctl.target;
                endcase
            end
        end
    end

    // Pixel request to the frame store
    always_comb
    begin
        px_ctl_next.valid = emit_walk || emit_read;
        px_ctl_next.write = emit_walk;
        px_ctl_next.both  = both_reg;
    end

    assign read_color = ((cmd_reg == CMD_READ) && rd_in) ? rd_color : '0;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            step_reg        <= STEP_FINISH;
            out_valid_reg   <= 1'b0;
            overhang_reg    <= OVERHANG_RESET;
            clear_color_reg <= CLEAR_COLOR_RESET;
            px_ctl_reg      <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            px_ctl_reg <= px_ctl_next;
            if (seq_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_OVERHANG: overhang_reg    <= cfg_data;
                    REG_CLEAR_COLOR:   clear_color_reg <= cfg_data;
                    default:           overhang_reg    <= overhang_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_in;
            xs_reg    <= xs_in;
            ys_reg    <= ys_in;
            xe_reg    <= xe_in;
            ye_reg    <= ye_in;
            pen_reg   <= pen_in;
            thick_reg <= thick_in;
            err_reg   <= err_next;
        end
        if (load_rect)
        begin
            cx_reg    <= r_x0;
            cy_reg    <= r_y0;
            x0_reg    <= r_x0;
            x1_reg    <= x1c;
            y1_reg    <= y1c;
            empty_reg <= r_empty;
            both_reg  <= (ctl.seg == SEG_FULL);
        end
        else if (emit_walk)
        begin
            if (x_last)
            begin
                cx_reg <= x0_reg;
                cy_reg <= cy_reg + CW'(1);
            end
            else
            begin
                cx_reg <= x_adv[CW-1:0];
            end
        end
        px_x_reg     <= emit_read ? XW'(xs_reg) : XW'(cx_reg);
        px_y_reg     <= emit_read ? YW'(ys_reg) : YW'(cy_reg);
        px_color_reg <= both_reg ? clear_color_reg : pen_reg;
        if (seq_finish)
        begin
            out_data_reg <= {3'b000, err_reg, read_color};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    p4fd_frame_mem #(
        .ROW_BYTES    (ROW_BYTES),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .XW           (XW),
        .YW           (YW)
    ) u_frame_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (px_ctl_reg),
        .x        (px_x_reg),
        .y        (px_y_reg),
        .color    (px_color_reg),
        .busy     (mem_busy),
        .rd_color (rd_color)
    );

    // Checks
    `P4FD_ASSERT_HOLDS(a_idle_quiet, !busy_reg, !px_ctl_reg.valid && !mem_busy,
        "pixel traffic while idle")
    `P4FD_ASSERT_HOLDS(a_px_in_frame, px_ctl_reg.valid,
        (int'(px_x_reg) < FRAME_WIDTH) && (int'(px_y_reg) < FRAME_HEIGHT),
        "pixel request outside frame")
    `P4FD_ASSERT_HOLDS(a_err_no_draw, busy_reg && err_reg,
        !(px_ctl_reg.valid && px_ctl_reg.write), "drawing on a range error")
    `P4FD_ASSERT_HOLDS(a_read_only_cmd, px_ctl_reg.valid && !px_ctl_reg.write,
        cmd_reg == CMD_READ, "read request outside read command")
    `P4FD_ASSERT_NEXT(a_finish_posts, seq_finish, m_tvalid,
        "finished command posted no result")

endmodule

// ----- sv/p4fd_frame_mem.sv -----
// Frame store with address pipeline. Even x lives in the high nibble array,
// odd x in the low nibble array; both arrays share one address.
module p4fd_frame_mem
    import p4fd_pkg::*;
#(
    parameter int ROW_BYTES    = 160,
    parameter int FRAME_HEIGHT = 240,
    parameter int XW           = 9,
    parameter int YW           = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  px_ctl_t            req,
    input  logic [XW-1:0]      x,
    input  logic [YW-1:0]      y,
    input  logic [COLOR_W-1:0] color,
    output logic               busy,
    output logic [COLOR_W-1:0] rd_color
);

    localparam int DEPTH = ROW_BYTES * FRAME_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    px_ctl_t            s1_ctl_reg;
    logic [AW-1:0]      s1_base_reg;
    logic [AW-1:0]      s1_col_reg;
    logic               s1_odd_reg;
    logic [COLOR_W-1:0] s1_color_reg;

    logic [AW-1:0]      addr;
    logic [COLOR_W-1:0] mem_hi [DEPTH];
    logic [COLOR_W-1:0] mem_lo [DEPTH];
    logic [COLOR_W-1:0] rd_hi_reg;
    logic [COLOR_W-1:0] rd_lo_reg;
    logic               rd_odd_reg;

    // Stage 1: row base multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_base_reg  <= AW'(y * ROW_BYTES);
        s1_col_reg   <= AW'(x >> 1);
        s1_odd_reg   <= x[0];
        s1_color_reg <= color;
    end

    // Stage 2: memory access
    assign addr = s1_base_reg + s1_col_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ctl_reg.valid && s1_ctl_reg.write)
        begin
            if (s1_ctl_reg.both || !s1_odd_reg)
            begin
                mem_hi[addr] <= s1_color_reg;
            end
            if (s1_ctl_reg.both || s1_odd_reg)
            begin
                mem_lo[addr] <= s1_color_reg;
            end
        end
        if (s1_ctl_reg.valid && !s1_ctl_reg.write)
        begin
            rd_hi_reg  <= mem_hi[addr];
            rd_lo_reg  <= mem_lo[addr];
            rd_odd_reg <= s1_odd_reg;
        end
    end

    assign rd_color = rd_odd_reg ? rd_lo_reg : rd_hi_reg;
    assign busy     = s1_ctl_reg.valid;

endmodule
